>>> rtl/rfa_pkg.sv
// Package for the rational fraction ALU: widths, opcodes, controller types.
package rfa_pkg;

    localparam int OperandBits = 16;
    localparam int MagBits     = 2 * OperandBits + 2;
    localparam int NumBits     = 33;
    localparam int DenBits     = 31;

    typedef enum logic [2:0] {
        OP_NORM = 3'd0,
        OP_ADD  = 3'd1,
        OP_MUL  = 3'd2,
        OP_EQ   = 3'd3,
        OP_LT   = 3'd4
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_GCD_A,
        ST_DIV_A,
        ST_LOAD_B,
        ST_GCD_B,
        ST_DIV_B,
        ST_COMBINE,
        ST_GCD_R,
        ST_DIV_R,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Datapath step selected by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_GCD_STEP,
        CMD_DIV_START,
        CMD_DIV_STEP,
        CMD_STORE_A,
        CMD_STORE_B,
        CMD_COMBINE,
        CMD_STORE_R,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } ctrl_t;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic need_reduce;
    } status_t;

endpackage

>>> rtl/rational_fraction_alu.sv
// Top level of the rational fraction ALU.
// Usage: one transaction on the input channel carries an opcode and two
// fractions a_num/a_den and b_num/b_den (16-bit two's complement). Each
// input transaction yields exactly one output transaction with res_num,
// res_den and cmp_flag.
// Both operands are normalized (zero denominator becomes one, gcd
// reduction, sign on the numerator); add and multiply results are reduced
// again. Each reduction runs a binary gcd and then a 34-step restoring
// divider, after which the quotients are stored.
// One transaction is worked on at a time and the next input is taken in
// the cycle after the result is taken.
// in_stall is high from acceptance until the result is taken.
// The result is held in out_valid with a stable payload while out_stall
// is high. Reset (rst_n low, asynchronous) returns the controller to idle
// and drops any transaction in progress.
module rational_fraction_alu (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         opcode,
    input  logic signed [15:0]                 a_num,
    input  logic signed [15:0]                 a_den,
    input  logic signed [15:0]                 b_num,
    input  logic signed [15:0]                 b_den,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [rfa_pkg::NumBits-1:0] res_num,
    output logic [rfa_pkg::DenBits-1:0]        res_den,
    output logic                               cmp_flag
);
    import rfa_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    rfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    rfa_datapath u_dp (
        .clk      (clk),
        .opcode   (opcode),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .ctrl     (ctrl),
        .status   (status),
        .res_num  (res_num),
        .res_den  (res_den),
        .cmp_flag (cmp_flag)
    );

endmodule

>>> rtl/rfa_ctrl.sv
// Controller state machine of the rational fraction ALU.
module rfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  rfa_pkg::status_t  status,
    output rfa_pkg::ctrl_t    ctrl
);
    import rfa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_LOAD_A;
            ST_LOAD_A:  state_next = ST_GCD_A;
            ST_GCD_A:   if (status.gcd_done) state_next = ST_DIV_A;
            ST_DIV_A:   if (status.div_done) state_next = ST_LOAD_B;
            ST_LOAD_B:  state_next = ST_GCD_B;
            ST_GCD_B:   if (status.gcd_done) state_next = ST_DIV_B;
            ST_DIV_B:   if (status.div_done) state_next = ST_COMBINE;
            ST_COMBINE: state_next = status.need_reduce ? ST_GCD_R : ST_FINISH;
            ST_GCD_R:   if (status.gcd_done) state_next = ST_DIV_R;
            ST_DIV_R:   if (status.div_done) state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_OUT;
            ST_OUT:     if (!out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        ctrl.cmd  = CMD_NONE;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) ctrl.cmd = CMD_CAPTURE;
            ST_LOAD_A:  ctrl.cmd = CMD_LOAD_A;
            ST_LOAD_B:  ctrl.cmd = CMD_LOAD_B;
            ST_COMBINE: ctrl.cmd = CMD_COMBINE;
            ST_GCD_A, ST_GCD_B, ST_GCD_R:
                ctrl.cmd = status.gcd_done ? CMD_DIV_START : CMD_GCD_STEP;
            ST_DIV_A:   ctrl.cmd = status.div_done ? CMD_STORE_A : CMD_DIV_STEP;
            ST_DIV_B:   ctrl.cmd = status.div_done ? CMD_STORE_B : CMD_DIV_STEP;
            ST_DIV_R:   ctrl.cmd = status.div_done ? CMD_STORE_R : CMD_DIV_STEP;
            ST_FINISH:  ctrl.cmd = CMD_FINISH;
            ST_OUT:     ctrl.cmd = CMD_NONE;
            default:    ctrl.cmd = CMD_NONE;
        endcase
    end

endmodule

>>> rtl/rfa_datapath.sv
// Datapath of the rational fraction ALU: operand registers, binary gcd, serial divider.
module rfa_datapath (
    input  logic                               clk,
    input  logic [2:0]                         opcode,
    input  logic signed [15:0]                 a_num,
    input  logic signed [15:0]                 a_den,
    input  logic signed [15:0]                 b_num,
    input  logic signed [15:0]                 b_den,
    input  rfa_pkg::ctrl_t                     ctrl,
    output rfa_pkg::status_t                   status,
    output logic signed [rfa_pkg::NumBits-1:0] res_num,
    output logic [rfa_pkg::DenBits-1:0]        res_den,
    output logic                               cmp_flag
);
    import rfa_pkg::*;

    localparam int OB = OperandBits;
    localparam int MB = MagBits;
    localparam int CW = $clog2(MB + 1);

    logic [2:0]      op_reg;
    logic [OB-1:0]   an_raw_reg, ad_raw_reg, bn_raw_reg, bd_raw_reg;
    // fraction a, b and working result as sign + magnitude
    logic            an_neg_reg, bn_neg_reg, w_neg_reg;
    logic [OB-1:0]   an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic [MB-1:0]   wn_reg, wd_reg;
    // gcd: binary algorithm
    logic [MB-1:0]   gx_reg, gy_reg;
    logic [CW-1:0]   gk_reg;
    // divider: restoring, one quotient bit per cycle for num and den in parallel
    logic [MB-1:0]   g_reg;
    logic [MB-1:0]   qn_reg, qd_reg, rn_reg, rd_reg;
    logic [CW-1:0]   dc_reg;
    logic            flag_reg;

    // Sign-magnitude conversion of an operand
    function automatic logic [OB:0] to_sm(input logic [OB-1:0] v);
        logic [OB-1:0] m;
        m = v[OB-1] ? (~v + 1'b1) : v;
        return {v[OB-1], m};
    endfunction

    logic [OB:0] sm_n, sm_d;
    logic [OB-1:0] src_n, src_d;
    assign src_n = (ctrl.cmd == CMD_LOAD_A) ? an_raw_reg : bn_raw_reg;
    assign src_d = (ctrl.cmd == CMD_LOAD_A) ? ad_raw_reg : bd_raw_reg;
    assign sm_n  = to_sm(src_n);
    assign sm_d  = to_sm(src_d);

    // Cross products and combine (products go through registers after)
    logic [MB-1:0] xa, xb, dprod, pprod;
    logic [MB-1:0] sum_mag;
    logic          sum_neg;
    assign xa    = MB'(an_mag_reg) * MB'(bd_mag_reg);
    assign xb    = MB'(bn_mag_reg) * MB'(ad_mag_reg);
    assign dprod = MB'(ad_mag_reg) * MB'(bd_mag_reg);
    assign pprod = MB'(an_mag_reg) * MB'(bn_mag_reg);

    always_comb
    begin
        if (an_neg_reg == bn_neg_reg)
        begin
            sum_neg = an_neg_reg;
            sum_mag = xa + xb;
        end
        else if (xa >= xb)
        begin
            sum_neg = an_neg_reg;
            sum_mag = xa - xb;
        end
        else
        begin
            sum_neg = bn_neg_reg;
            sum_mag = xb - xa;
        end
    end

    logic lt_flag;
    always_comb
    begin
        if (an_neg_reg != bn_neg_reg)
            lt_flag = an_neg_reg;
        else
            lt_flag = an_neg_reg ? (xa > xb) : (xa < xb);
    end

    // Binary gcd step; gx, gy both nonzero unless one is zero
    logic gcd_done;
    assign gcd_done = (gx_reg == '0) || (gy_reg == '0) || (gx_reg == gy_reg);
    logic [MB-1:0] gcd_val;
    assign gcd_val = ((gx_reg == '0) ? gy_reg : gx_reg) << gk_reg;

    // Divider step
    logic [MB:0] tn, td;
    assign tn = {rn_reg, qn_reg[MB-1]} - {1'b0, g_reg};
    assign td = {rd_reg, qd_reg[MB-1]} - {1'b0, g_reg};

    assign status.gcd_done    = gcd_done;
    assign status.div_done    = (dc_reg == CW'(MB));
    assign status.need_reduce = (op_reg == OP_ADD) || (op_reg == OP_MUL);

    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            CMD_CAPTURE:
            begin
                op_reg     <= opcode;
                an_raw_reg <= OB'(a_num);
                ad_raw_reg <= OB'(a_den);
                bn_raw_reg <= OB'(b_num);
                bd_raw_reg <= OB'(b_den);
            end
            CMD_LOAD_A, CMD_LOAD_B:
            begin
                wn_reg <= MB'(sm_n[OB-1:0]);
                if (sm_d[OB-1:0] == '0)
                begin
                    wd_reg    <= MB'(1);
                    w_neg_reg <= sm_n[OB];
                end
                else
                begin
                    wd_reg    <= MB'(sm_d[OB-1:0]);
                    w_neg_reg <= sm_n[OB] ^ sm_d[OB];
                end
                gx_reg <= MB'(sm_n[OB-1:0]);
                gy_reg <= (sm_d[OB-1:0] == '0) ? MB'(1) : MB'(sm_d[OB-1:0]);
                gk_reg <= '0;
            end
            CMD_COMBINE:
            begin
                if (op_reg == OP_ADD)
                begin
                    wn_reg <= sum_mag; w_neg_reg <= sum_neg;
                    wd_reg <= dprod;
                    gx_reg <= sum_mag; gy_reg <= dprod;
                end
                else
                begin
                    wn_reg <= pprod; w_neg_reg <= an_neg_reg ^ bn_neg_reg;
                    wd_reg <= dprod;
                    gx_reg <= pprod; gy_reg <= dprod;
                end
                gk_reg   <= '0;
                flag_reg <= (op_reg == OP_EQ)
                    ? ((an_neg_reg == bn_neg_reg) && (an_mag_reg == bn_mag_reg)
                       && (ad_mag_reg == bd_mag_reg))
                    : ((op_reg == OP_LT) && lt_flag);
            end
            CMD_GCD_STEP:
            begin
                priority if (!gx_reg[0] && !gy_reg[0])
                begin
                    gx_reg <= gx_reg >> 1; gy_reg <= gy_reg >> 1;
                    gk_reg <= gk_reg + 1'b1;
                end
                else if (!gx_reg[0])
                    gx_reg <= gx_reg >> 1;
                else if (!gy_reg[0])
                    gy_reg <= gy_reg >> 1;
                else if (gx_reg > gy_reg)
                    gx_reg <= (gx_reg - gy_reg) >> 1;
                else
                    gy_reg <= (gy_reg - gx_reg) >> 1;
            end
            CMD_DIV_START:
            begin
                g_reg  <= gcd_val;
                qn_reg <= wn_reg; qd_reg <= wd_reg;
                rn_reg <= '0;     rd_reg <= '0;
                dc_reg <= '0;
            end
            CMD_DIV_STEP:
            begin
                if (!tn[MB]) begin rn_reg <= tn[MB-1:0]; qn_reg <= {qn_reg[MB-2:0], 1'b1}; end
                else begin rn_reg <= {rn_reg[MB-2:0], qn_reg[MB-1]}; qn_reg <= {qn_reg[MB-2:0], 1'b0}; end
                if (!td[MB]) begin rd_reg <= td[MB-1:0]; qd_reg <= {qd_reg[MB-2:0], 1'b1}; end
                else begin rd_reg <= {rd_reg[MB-2:0], qd_reg[MB-1]}; qd_reg <= {qd_reg[MB-2:0], 1'b0}; end
                dc_reg <= dc_reg + 1'b1;
            end
            CMD_STORE_A:
            begin
                an_mag_reg <= OB'(qn_reg); ad_mag_reg <= OB'(qd_reg);
                an_neg_reg <= w_neg_reg && (qn_reg != '0);
            end
            CMD_STORE_B:
            begin
                bn_mag_reg <= OB'(qn_reg); bd_mag_reg <= OB'(qd_reg);
                bn_neg_reg <= w_neg_reg && (qn_reg != '0);
            end
            CMD_STORE_R:
            begin
                wn_reg <= qn_reg; wd_reg <= qd_reg;
                w_neg_reg <= w_neg_reg && (qn_reg != '0);
            end
            CMD_FINISH:
            begin
                unique case (op_reg)
                    OP_NORM:
                    begin
                        res_num <= an_neg_reg ? -NumBits'(an_mag_reg) : NumBits'(an_mag_reg);
                        res_den <= DenBits'(ad_mag_reg);
                        cmp_flag <= 1'b0;
                    end
                    OP_ADD, OP_MUL:
                    begin
                        res_num <= w_neg_reg ? -NumBits'(wn_reg) : NumBits'(wn_reg);
                        res_den <= DenBits'(wd_reg);
                        cmp_flag <= 1'b0;
                    end
                    OP_EQ, OP_LT:
                    begin
                        res_num <= '0; res_den <= DenBits'(1); cmp_flag <= flag_reg;
                    end
                    default:
                    begin
                        res_num <= '0; res_den <= DenBits'(1); cmp_flag <= 1'b0;
                    end
                endcase
            end
            default: ;
        endcase
    end

endmodule
